FILE: sv/mrmu_pkg.sv
package mrmu_pkg;

    localparam int NUM_FEATURES = 32;
    localparam int TABLE_DEPTH  = 32;
    localparam int NUM_USED     = (NUM_FEATURES < TABLE_DEPTH) ? NUM_FEATURES : TABLE_DEPTH;
    localparam int IDX_W        = 5;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_USED - 1);

    // Restoring division runs one quotient bit per cycle over a 64-bit dividend.
    localparam int DIV_STEPS  = 64;
    localparam int DIV_CNT_W  = 7;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef struct packed {
        logic              op;
        logic [31:0]       feature_mask;
        logic              stop_flag;
        logic signed [31:0] reward;
        logic [IDX_W-1:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic               status;
        logic signed [31:0] score_out;
        logic [31:0]        count_out;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_SCAN,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic rd_en;
        logic rd_sel_read;
        logic idx_clr;
        logic idx_inc;
        logic mul;
        logic add;
        logic div_step;
        logic wr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic op_read;
        logic stop;
        logic mask_bit;
        logic idx_last;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

FILE: sv/masked_running_mean_update.sv
// Channel | Direction | Handshake                   | Payload
// in      | input     | i_in_valid / o_in_stall     | i_in_item  (mrmu_pkg::t_in_item)
// out     | output    | o_out_valid / i_out_stall   | o_out_item (mrmu_pkg::t_out_item)
//
// One item at a time. A read passes the decode and read states, a refused update only
// decode, before the result is registered. An accepted update scans all NUM_USED
// entries and per feature set in the mask multiplies, adds, runs the one-bit-per-cycle
// divider and writes back. Reset clears the sample store through per-entry valid bits.
// A held result does not block the next item from being accepted.
module masked_running_mean_update (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mrmu_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mrmu_pkg::t_out_item o_out_item
);

    mrmu_pkg::t_dp_cmd    w_cmd;
    mrmu_pkg::t_dp_status w_status;

    mrmu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    mrmu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: sv/mrmu_ctrl.sv
module mrmu_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  mrmu_pkg::t_dp_status  i_status,
    output logic                  o_in_stall,
    output mrmu_pkg::t_dp_cmd     o_cmd
);

    mrmu_pkg::t_state r_state;
    mrmu_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrmu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mrmu_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = mrmu_pkg::ST_DECODE;
                end
            end
            mrmu_pkg::ST_DECODE: begin
                if (i_status.op_read) begin
                    n_state = mrmu_pkg::ST_READ;
                end else if (i_status.stop) begin
                    n_state = mrmu_pkg::ST_SCAN;
                end else begin
                    n_state = mrmu_pkg::ST_DONE;
                end
            end
            mrmu_pkg::ST_READ: n_state = mrmu_pkg::ST_DONE;
            mrmu_pkg::ST_SCAN: begin
                if (i_status.mask_bit) begin
                    n_state = mrmu_pkg::ST_MUL;
                end else if (i_status.idx_last) begin
                    n_state = mrmu_pkg::ST_DONE;
                end
            end
            mrmu_pkg::ST_MUL: n_state = mrmu_pkg::ST_ADD;
            mrmu_pkg::ST_ADD: n_state = mrmu_pkg::ST_DIV;
            mrmu_pkg::ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = mrmu_pkg::ST_WRITE;
                end
            end
            mrmu_pkg::ST_WRITE: begin
                if (i_status.idx_last) begin
                    n_state = mrmu_pkg::ST_DONE;
                end else begin
                    n_state = mrmu_pkg::ST_SCAN;
                end
            end
            mrmu_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = mrmu_pkg::ST_IDLE;
                end
            end
            default: n_state = mrmu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            mrmu_pkg::ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            mrmu_pkg::ST_DECODE: begin
                o_cmd.idx_clr = 1'b1;
            end
            mrmu_pkg::ST_READ: begin
                o_cmd.rd_en       = 1'b1;
                o_cmd.rd_sel_read = 1'b1;
            end
            mrmu_pkg::ST_SCAN: begin
                o_cmd.rd_en   = i_status.mask_bit;
                o_cmd.idx_inc = !i_status.mask_bit && !i_status.idx_last;
            end
            mrmu_pkg::ST_MUL: o_cmd.mul = 1'b1;
            mrmu_pkg::ST_ADD: o_cmd.add = 1'b1;
            mrmu_pkg::ST_DIV: o_cmd.div_step = !i_status.div_done;
            mrmu_pkg::ST_WRITE: begin
                o_cmd.wr      = 1'b1;
                o_cmd.idx_inc = !i_status.idx_last;
            end
            mrmu_pkg::ST_DONE: o_cmd.out_load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: sv/mrmu_dp.sv
module mrmu_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mrmu_pkg::t_in_item    i_in_item,
    input  logic                  i_out_stall,
    input  mrmu_pkg::t_dp_cmd     i_cmd,
    output mrmu_pkg::t_dp_status  o_status,
    output logic                  o_out_valid,
    output mrmu_pkg::t_out_item   o_out_item
);

    mrmu_pkg::t_in_item r_in;
    logic [mrmu_pkg::IDX_W-1:0] r_idx;

    logic signed [31:0] r_score_mem [mrmu_pkg::TABLE_DEPTH];
    logic [31:0]        r_count_mem [mrmu_pkg::TABLE_DEPTH];
    logic [mrmu_pkg::TABLE_DEPTH-1:0] r_valid;

    logic signed [31:0] r_rd_score;
    logic [31:0]        r_rd_count;

    logic signed [63:0] r_prod;
    logic [31:0]        r_cnt;
    logic               r_neg;
    logic [63:0]        r_dvd;
    logic [32:0]        r_rem;
    logic [32:0]        r_div;
    logic [mrmu_pkg::DIV_CNT_W-1:0] r_step;

    logic               r_out_valid;
    mrmu_pkg::t_out_item r_out;

    logic [mrmu_pkg::IDX_W-1:0] w_rd_addr;
    logic signed [64:0] w_prod;
    logic signed [63:0] w_num;
    logic [63:0]        w_abs;
    logic [33:0]        w_rem_sh;
    logic [34:0]        w_diff;
    logic               w_qbit;
    logic [31:0]        w_q;
    logic signed [31:0] w_new_score;
    logic [31:0]        w_new_count;
    logic               w_refused;

    assign w_rd_addr = i_cmd.rd_sel_read ? r_in.read_index : r_idx;

    assign w_prod = r_rd_score * $signed({1'b0, r_rd_count});
    assign w_num  = r_prod + {{32{r_in.reward[31]}}, r_in.reward};
    assign w_abs  = w_num[63] ? (64'd0 - w_num) : w_num;

    // One restoring step: the remainder stays below the divisor, at most 2^32.
    assign w_rem_sh = {r_rem, r_dvd[63]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_div};
    assign w_qbit   = !w_diff[34];

    assign w_q         = r_dvd[31:0];
    assign w_new_score = r_neg ? (32'sd0 - $signed(w_q)) : $signed(w_q);
    assign w_new_count = (r_cnt == '1) ? r_cnt : (r_cnt + 32'd1);

    assign w_refused = (r_in.op == mrmu_pkg::OP_UPDATE) && !r_in.stop_flag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_item;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.wr) begin
            r_valid[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_score_mem[r_idx] <= w_new_score;
            r_count_mem[r_idx] <= w_new_count;
        end
        if (i_cmd.rd_en) begin
            r_rd_score <= r_valid[w_rd_addr] ? r_score_mem[w_rd_addr] : 32'sd0;
            r_rd_count <= r_valid[w_rd_addr] ? r_count_mem[w_rd_addr] : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= w_prod[63:0];
            r_cnt  <= r_rd_count;
        end
        if (i_cmd.add) begin
            r_neg  <= w_num[63];
            r_dvd  <= w_abs;
            r_rem  <= '0;
            r_div  <= {1'b0, r_cnt} + 33'd1;
            r_step <= mrmu_pkg::DIV_CNT_W'(mrmu_pkg::DIV_STEPS);
        end else if (i_cmd.div_step) begin
            r_rem  <= w_qbit ? w_diff[32:0] : w_rem_sh[32:0];
            r_dvd  <= {r_dvd[62:0], w_qbit};
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status    <= w_refused ? mrmu_pkg::STATUS_REFUSED : mrmu_pkg::STATUS_OK;
            r_out.score_out <= (r_in.op == mrmu_pkg::OP_READ) ? r_rd_score : 32'sd0;
            r_out.count_out <= (r_in.op == mrmu_pkg::OP_READ) ? r_rd_count : 32'd0;
        end
    end

    assign o_status.op_read  = (r_in.op == mrmu_pkg::OP_READ);
    assign o_status.stop     = r_in.stop_flag;
    assign o_status.mask_bit = r_in.feature_mask[r_idx];
    assign o_status.idx_last = (r_idx == mrmu_pkg::LAST_IDX);
    assign o_status.div_done = (r_step == '0);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: sv/mrmu_checker.sv
module mrmu_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_stall,
    input logic                i_out_valid,
    input logic                i_out_stall,
    input mrmu_pkg::t_out_item i_out_item
);

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_out_item)))
        else $error("stalled result changed");

    // A refused update carries no score and no count.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_item.status == mrmu_pkg::STATUS_REFUSED))
        |-> (i_out_item.score_out == 32'sd0 && i_out_item.count_out == 32'd0))
        else $error("refused update returned data");

    // The block is busy in the cycle after it takes an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_stall) |=> i_in_stall)
        else $error("item accepted while previous item in flight");

    // A new result only appears after the block has been working on an item.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_stall))
        else $error("result appeared without work");

endmodule

bind masked_running_mean_update mrmu_checker u_mrmu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);

FILE: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrmu_pkg::*;

    localparam int RANDOM_ITEMS = 258;
    localparam int HANG_LIMIT   = 12000;
    localparam int TAIL_CYCLES  = 100;

    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item want;
    } t_row;

    logic      clk;
    logic      rst_n;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // Predicted contents of the score and count store.
    int          mean_q[TABLE_DEPTH];
    int unsigned tally[TABLE_DEPTH];

    t_out_item   pending_results[$];
    t_row        plan[$];
    int unsigned mismatches = 0;
    bit          calm = 1'b0;
    int unsigned stall_hold = 0;

    masked_running_mean_update dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: %s mismatch at %0t: got %h, expected %h", what, $time, got, want);
        mismatches++;
    endtask

    // Applies one item to the predicted store and returns the result it should produce.
    function automatic t_out_item mean_update_result(t_in_item it);
        t_out_item r;
        longint    cnt;
        longint    num;
        int        rw;
        r  = '0;
        rw = it.reward;
        if (it.op == OP_READ) begin
            if (it.read_index < NUM_USED) begin
                r.score_out = mean_q[it.read_index];
                r.count_out = tally[it.read_index];
            end
        end else if (!it.stop_flag) begin
            r.status = STATUS_REFUSED;
        end else begin
            for (int i = 0; i < NUM_USED; i++) begin
                if (it.feature_mask[i]) begin
                    cnt       = longint'(tally[i]);
                    num       = longint'(mean_q[i]) * cnt + longint'(rw);
                    mean_q[i] = int'(num / (cnt + 1));
                    if (tally[i] != 32'hFFFF_FFFF) begin
                        tally[i]++;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_reward();
        case ($urandom_range(0, 9))
            0: begin
                return 32'h8000_0000;
            end
            1: begin
                return 32'h7FFF_FFFF;
            end
            2, 3, 4: begin
                return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_mask();
        logic [31:0] m;
        case ($urandom_range(0, 9))
            0: begin
                return 32'hFFFF_FFFF;
            end
            1, 2: begin
                return $urandom;
            end
            3: begin
                return 32'd1 << $urandom_range(0, 31);
            end
            default: begin
                // Sparse masks keep the per-item update time short.
                m = '0;
                repeat ($urandom_range(1, 3)) m[$urandom_range(0, 31)] = 1'b1;
                return m;
            end
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned kind;
        kind            = $urandom_range(0, 99);
        it.feature_mask = $urandom;
        it.stop_flag    = $urandom_range(0, 1);
        it.reward       = $urandom;
        it.read_index   = $urandom_range(0, 31);
        if (kind < 35) begin
            it.op = OP_READ;
        end else if (kind < 45) begin
            it.op        = OP_UPDATE;
            it.stop_flag = 1'b0;
        end else begin
            it.op           = OP_UPDATE;
            it.stop_flag    = 1'b1;
            it.feature_mask = pick_mask();
            it.reward       = pick_reward();
        end
        return it;
    endfunction

    function automatic void add_row(logic op, logic [31:0] mask, logic stop, logic [31:0] rw,
                                    logic [IDX_W-1:0] idx, bit typed, logic st,
                                    logic [31:0] sc, logic [31:0] ct);
        t_row r;
        r.stim  = '{op: op, feature_mask: mask, stop_flag: stop, reward: rw, read_index: idx};
        r.typed = typed;
        r.want  = '{status: st, score_out: sc, count_out: ct};
        plan.insert(plan.size(), r);
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic offer_item(t_in_item it, bit typed, t_out_item want);
        int unsigned gap;
        t_out_item   got;
        gap = calm ? 0 : gap_length();
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do @(posedge clk); while (in_stall);
        got = mean_update_result(it);
        pending_results.insert(pending_results.size(), typed ? want : got);
        @(negedge clk);
    endtask

    always @(negedge clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if (calm) begin
            out_stall <= 1'b0;
        end else begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_hold <= gap_length();
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", out_item.score_out, '0);
            end else begin
                want = pending_results.pop_front();
                if (out_item.status !== want.status) begin
                    report_mismatch("status", out_item.status, want.status);
                end
                if (out_item.score_out !== want.score_out) begin
                    report_mismatch("score_out", out_item.score_out, want.score_out);
                end
                if (out_item.count_out !== want.count_out) begin
                    report_mismatch("count_out", out_item.count_out, want.count_out);
                end
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    initial begin
        int unsigned hung;
        hung = 0;
        @(posedge rst_n);
        while (hung < HANG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                hung = 0;
            end else begin
                hung++;
            end
        end
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            mean_q[i] = 0;
            tally[i]  = 0;
        end

        // Empty store, refusal, both reward extremes on the edge features, empty mask,
        // and reads that carry junk in the fields a read ignores.
        add_row(OP_READ,   32'h0,         1'b0, 32'h0,         5'd0,  1, STATUS_OK, 0, 0);
        add_row(OP_READ,   32'h0,         1'b0, 32'h0,         5'd31, 1, STATUS_OK, 0, 0);
        add_row(OP_UPDATE, 32'hFFFF_FFFF, 1'b0, 32'h5,         5'd0,  1, STATUS_REFUSED, 0, 0);
        add_row(OP_READ,   32'h0,         1'b0, 32'h0,         5'd5,  1, STATUS_OK, 0, 0);
        add_row(OP_UPDATE, 32'h1,         1'b1, 32'h8000_0000, 5'd0,  1, STATUS_OK, 0, 0);
        add_row(OP_READ,   32'h0,         1'b0, 32'h0,         5'd0,  1, STATUS_OK,
                32'h8000_0000, 1);
        add_row(OP_UPDATE, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 5'd3,  1, STATUS_OK, 0, 0);
        add_row(OP_READ,   32'h0,         1'b0, 32'h0,         5'd31, 1, STATUS_OK,
                32'h7FFF_FFFF, 1);
        add_row(OP_UPDATE, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 5'd0,  1, STATUS_OK, 0, 0);
        add_row(OP_READ,   32'h0,         1'b0, 32'h0,         5'd0,  0, STATUS_OK, 0, 0);
        add_row(OP_READ,   32'h0,         1'b0, 32'h0,         5'd31, 0, STATUS_OK, 0, 0);
        add_row(OP_UPDATE, 32'h0,         1'b1, 32'd123,       5'd9,  1, STATUS_OK, 0, 0);
        add_row(OP_READ,   32'hDEAD_BEEF, 1'b0, 32'hCAFE_F00D, 5'd7,  0, STATUS_OK, 0, 0);
        add_row(OP_READ,   32'h1234_5678, 1'b1, 32'h8765_4321, 5'd7,  0, STATUS_OK, 0, 0);
        add_row(OP_UPDATE, 32'hAAAA_AAAA, 1'b1, 32'hFFFF_FFFF, 5'd0,  1, STATUS_OK, 0, 0);
        add_row(OP_UPDATE, 32'h5555_5555, 1'b1, 32'h0001_0000, 5'd31, 1, STATUS_OK, 0, 0);
        add_row(OP_READ,   32'h0,         1'b0, 32'h0,         5'd1,  0, STATUS_OK, 0, 0);
        add_row(OP_READ,   32'h0,         1'b0, 32'h0,         5'd2,  0, STATUS_OK, 0, 0);
        add_row(OP_UPDATE, 32'h0,         1'b0, 32'h8000_0000, 5'd31, 1, STATUS_REFUSED, 0, 0);
        add_row(OP_UPDATE, 32'hFFFF_0000, 1'b1, 32'h8000_0000, 5'd0,  1, STATUS_OK, 0, 0);
        add_row(OP_READ,   32'h0,         1'b0, 32'h0,         5'd30, 0, STATUS_OK, 0, 0);
        add_row(OP_READ,   32'h0,         1'b0, 32'h0,         5'd15, 0, STATUS_OK, 0, 0);

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[k]) begin
            offer_item(plan[k].stim, plan[k].typed, plan[k].want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 60 && n < 100);
            if (n == 150) begin
                // Let the block drain completely before carrying on.
                in_valid = 1'b0;
                @(negedge clk);
                while (pending_results.size() != 0) @(negedge clk);
            end
            offer_item(random_item(), 1'b0, '0);
        end
        in_valid = 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
